// File: hdl/cial_pkg.sv
`default_nettype none

package cial_pkg;

	localparam int MAX_INTERVALS_DEF = 64;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic signed [31:0] HEADING_MISS = 32'sh7FFF_FFFF;

	// last step of the polynomial sequence
	localparam logic [2:0] POLY_LAST = 3'd6;

	typedef struct packed {
		logic signed [31:0] start_pos;
		logic signed [31:0] end_pos;
		logic signed [31:0] start_curv;
		logic signed [63:0] slope;
		logic signed [47:0] start_angle;
	} entry_t;

	typedef enum logic [2:0] {
		MUL_SQ,
		MUL_C,
		MUL_M0,
		MUL_M1,
		MUL_M2,
		MUL_M3
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_INIT,
		ACC_SQ,
		ACC_ADD_C,
		ACC_ADD_M0,
		ACC_ADD_M1,
		ACC_ADD_M2,
		ACC_ADD_M3
	} acc_sel_t;

	typedef struct packed {
		logic     capture;
		logic     latch_entry;
		mul_sel_t mul_sel;
		acc_sel_t acc_sel;
		logic     a0_zero;
		logic     emit;
		logic     emit_found;
	} dp_cmd_t;

endpackage

`default_nettype wire

// File: hdl/cial_ram.sv
`default_nettype none

module cial_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: hdl/cial_div.sv
`default_nettype none

// Restoring divider: trunc((dy << 30) / dx), one quotient bit per cycle.
module cial_div
	import cial_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [32:0] dy,
	input  wire logic signed [32:0] dx,
	output logic                    busy,
	output logic signed [63:0]      quotient
);

	localparam logic [5:0] LAST_STEP = 6'd62;

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [62:0] num_q;
	logic [31:0] den_q;
	logic        neg_q;
	logic        zero_q;

	logic [32:0] dy_mag;
	logic [32:0] dx_mag;
	logic [32:0] trial;
	logic [32:0] diff;
	logic        ge;

	assign dy_mag = dy[32] ? -dy : dy;
	assign dx_mag = dx[32] ? -dx : dx;
	assign trial  = {rem_q, num_q[62]};
	assign diff   = trial - {1'b0, den_q};
	assign ge     = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			num_q  <= {1'b0, dy_mag[31:0], 30'b0};
			den_q  <= dx_mag[31:0];
			neg_q  <= dy[32] ^ dx[32];
			zero_q <= (dx == '0);
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			num_q <= {num_q[61:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = zero_q ? 64'sd0 :
		(neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q}));

endmodule

`default_nettype wire

// File: hdl/cial_dp.sv
`default_nettype none

module cial_dp
	import cial_pkg::*;
(
	input  wire logic               clk,
	input  wire dp_cmd_t            cmd_in,
	input  wire logic signed [31:0] position,
	input  wire logic signed [31:0] end_position,
	input  wire logic signed [31:0] start_curvature,
	input  wire logic signed [31:0] end_curvature,
	input  wire entry_t             rd_entry,
	input  wire logic signed [63:0] div_quotient,
	output logic signed [32:0]      div_dy,
	output logic signed [32:0]      div_dx,
	output entry_t                  wr_entry,
	output logic                    hit,
	output logic signed [31:0]      heading,
	output logic                    found
);

	logic signed [31:0] pos_q;
	logic signed [31:0] endp_q;
	logic signed [31:0] c0in_q;
	logic signed [31:0] c1in_q;

	logic               dneg_q;
	logic [31:0]        dm_q;
	logic               cneg_q;
	logic [31:0]        cmag_q;
	logic               mneg_q;
	logic [63:0]        mmag_q;
	logic signed [47:0] a0_q;

	logic [63:0]  sq_q;
	logic [63:0]  prod_q;
	logic [127:0] acc_q;

	logic signed [31:0] heading_q;
	logic               found_q;

	logic signed [32:0] d;
	logic [32:0]        d_mag;
	logic [63:0]        slope_mag;
	logic [31:0]        curv_mag;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [127:0]       addend;
	logic               sub;
	logic               add_en;
	logic [47:0]        sat48;
	logic [31:0]        sat32;

	assign div_dx = {endp_q[31], endp_q} - {pos_q[31], pos_q};
	assign div_dy = {c1in_q[31], c1in_q} - {c0in_q[31], c0in_q};

	assign hit = (pos_q >= rd_entry.start_pos) && (pos_q <= rd_entry.end_pos);

	assign d         = {pos_q[31], pos_q} - {rd_entry.start_pos[31], rd_entry.start_pos};
	assign d_mag     = d[32] ? -d : d;
	assign slope_mag = rd_entry.slope[63] ? -rd_entry.slope : rd_entry.slope;
	assign curv_mag  = rd_entry.start_curv[31] ? -rd_entry.start_curv : rd_entry.start_curv;

	always_comb begin
		case (cmd_in.mul_sel)
			MUL_SQ: begin
				mul_a = dm_q;
				mul_b = dm_q;
			end
			MUL_C: begin
				mul_a = cmag_q;
				mul_b = dm_q;
			end
			MUL_M0: begin
				mul_a = mmag_q[31:0];
				mul_b = sq_q[31:0];
			end
			MUL_M1: begin
				mul_a = mmag_q[31:0];
				mul_b = sq_q[63:32];
			end
			MUL_M2: begin
				mul_a = mmag_q[63:32];
				mul_b = sq_q[31:0];
			end
			MUL_M3: begin
				mul_a = mmag_q[63:32];
				mul_b = sq_q[63:32];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// partial products are summed at 77 fraction bits, sign applied per term
	always_comb begin
		addend = {64'b0, prod_q};
		sub    = mneg_q;
		add_en = 1'b1;
		case (cmd_in.acc_sel)
			ACC_ADD_C: begin
				addend = {64'b0, prod_q} << 31;
				sub    = cneg_q ^ dneg_q;
			end
			ACC_ADD_M0: addend = {64'b0, prod_q};
			ACC_ADD_M1: addend = {64'b0, prod_q} << 32;
			ACC_ADD_M2: addend = {64'b0, prod_q} << 32;
			ACC_ADD_M3: addend = {64'b0, prod_q} << 64;
			default: add_en = 1'b0;
		endcase
	end

	// value is acc >>> 49; saturate on the upper bits
	always_comb begin
		if ((&acc_q[127:96]) || !(|acc_q[127:96])) begin
			sat48 = acc_q[96:49];
		end else begin
			sat48 = acc_q[127] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
		end
		if ((&acc_q[127:80]) || !(|acc_q[127:80])) begin
			sat32 = acc_q[80:49];
		end else begin
			sat32 = acc_q[127] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_in.capture) begin
			pos_q  <= position;
			endp_q <= end_position;
			c0in_q <= start_curvature;
			c1in_q <= end_curvature;
		end
		if (cmd_in.latch_entry) begin
			dneg_q <= d[32];
			dm_q   <= d_mag[31:0];
			cneg_q <= rd_entry.start_curv[31];
			cmag_q <= curv_mag;
			mneg_q <= rd_entry.slope[63];
			mmag_q <= slope_mag;
			a0_q   <= rd_entry.start_angle;
		end
		prod_q <= mul_a * mul_b;
		if (cmd_in.acc_sel == ACC_INIT) begin
			acc_q <= {{31{a0_q[47]}}, a0_q, 49'b0};
		end else if (add_en) begin
			acc_q <= sub ? (acc_q - addend) : (acc_q + addend);
		end
		if (cmd_in.acc_sel == ACC_SQ) begin
			sq_q <= prod_q;
		end
		if (cmd_in.emit) begin
			heading_q <= cmd_in.emit_found ? $signed(sat32) : HEADING_MISS;
			found_q   <= cmd_in.emit_found;
		end
	end

	always_comb begin
		wr_entry.start_pos   = pos_q;
		wr_entry.end_pos     = endp_q;
		wr_entry.start_curv  = c0in_q;
		wr_entry.slope       = div_quotient;
		wr_entry.start_angle = cmd_in.a0_zero ? 48'sd0 : $signed(sat48);
	end

	assign heading = heading_q;
	assign found   = found_q;

endmodule

`default_nettype wire

// File: hdl/cial_ctrl.sv
`default_nettype none

module cial_ctrl
	import cial_pkg::*;
#(
	parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
	localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1,
	localparam int CW = $clog2(MAX_INTERVALS + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_stall,
	input  wire logic          cmd,
	input  wire logic [5:0]    slot,
	input  wire logic          hit,
	input  wire logic          div_busy,
	output logic               div_start,
	output logic [AW-1:0]      raddr,
	output logic               we,
	output logic [AW-1:0]      waddr,
	output dp_cmd_t            dp_cmd,
	output logic               result_valid,
	input  wire logic          result_stall
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_LOAD     = 9'b000000010,
		S_LD_RD    = 9'b000000100,
		S_LD_LAT   = 9'b000001000,
		S_WALK     = 9'b000010000,
		S_POLY     = 9'b000100000,
		S_DIV_WAIT = 9'b001000000,
		S_WRITE    = 9'b010000000,
		S_EMIT     = 9'b100000000
	} state_t;

	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_INTERVALS);

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] widx_q;
	logic [CW-1:0] idx_q;
	logic          pend_q;
	logic          is_load_q;
	logic          found_q;
	logic [2:0]    step_q;
	logic          result_valid_q;

	logic [CW-1:0] eff_count;
	logic [CW-1:0] prev_idx;
	logic          out_free;

	assign eff_count = (slot == 6'd0) ? '0 : count_q;
	assign prev_idx  = widx_q - CW'(1);
	assign out_free  = !result_valid_q || !result_stall;

	always_comb begin
		item_stall         = (state_q != S_IDLE);
		div_start          = 1'b0;
		raddr              = '0;
		we                 = 1'b0;
		waddr              = widx_q[AW-1:0];
		dp_cmd.capture     = 1'b0;
		dp_cmd.latch_entry = 1'b0;
		dp_cmd.mul_sel     = MUL_SQ;
		dp_cmd.acc_sel     = ACC_HOLD;
		dp_cmd.a0_zero     = (widx_q == '0);
		dp_cmd.emit        = 1'b0;
		dp_cmd.emit_found  = found_q;
		unique case (state_q)
			S_IDLE: dp_cmd.capture = item_valid;
			S_LOAD: div_start = 1'b1;
			S_LD_RD: raddr = prev_idx[AW-1:0];
			S_LD_LAT: dp_cmd.latch_entry = 1'b1;
			S_WALK: begin
				raddr              = idx_q[AW-1:0];
				dp_cmd.latch_entry = pend_q && hit;
			end
			S_POLY: begin
				case (step_q)
					3'd0: begin
						dp_cmd.mul_sel = MUL_SQ;
						dp_cmd.acc_sel = ACC_INIT;
					end
					3'd1: begin
						dp_cmd.mul_sel = MUL_C;
						dp_cmd.acc_sel = ACC_SQ;
					end
					3'd2: begin
						dp_cmd.mul_sel = MUL_M0;
						dp_cmd.acc_sel = ACC_ADD_C;
					end
					3'd3: begin
						dp_cmd.mul_sel = MUL_M1;
						dp_cmd.acc_sel = ACC_ADD_M0;
					end
					3'd4: begin
						dp_cmd.mul_sel = MUL_M2;
						dp_cmd.acc_sel = ACC_ADD_M1;
					end
					3'd5: begin
						dp_cmd.mul_sel = MUL_M3;
						dp_cmd.acc_sel = ACC_ADD_M2;
					end
					3'd6: dp_cmd.acc_sel = ACC_ADD_M3;
					default: dp_cmd.acc_sel = ACC_HOLD;
				endcase
			end
			S_DIV_WAIT: ;
			S_WRITE: we = 1'b1;
			S_EMIT: dp_cmd.emit = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			widx_q         <= '0;
			idx_q          <= '0;
			pend_q         <= 1'b0;
			is_load_q      <= 1'b0;
			found_q        <= 1'b0;
			step_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (dp_cmd.emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						if (cmd == CMD_QUERY) begin
							is_load_q <= 1'b0;
							idx_q     <= '0;
							pend_q    <= 1'b0;
							state_q   <= S_WALK;
						end else begin
							if (slot == 6'd0) begin
								count_q <= '0;
							end
							// a full table drops the word
							if (eff_count < MAX_CNT) begin
								is_load_q <= 1'b1;
								widx_q    <= eff_count;
								state_q   <= S_LOAD;
							end
						end
					end
				end
				S_LOAD: state_q <= (widx_q == '0) ? S_DIV_WAIT : S_LD_RD;
				S_LD_RD: state_q <= S_LD_LAT;
				S_LD_LAT: begin
					step_q  <= '0;
					state_q <= S_POLY;
				end
				S_WALK: begin
					if (idx_q < count_q) begin
						idx_q  <= idx_q + CW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q && hit) begin
						found_q <= 1'b1;
						step_q  <= '0;
						state_q <= S_POLY;
					end else if (!pend_q && idx_q == count_q) begin
						found_q <= 1'b0;
						state_q <= S_EMIT;
					end
				end
				S_POLY: begin
					step_q <= step_q + 3'd1;
					if (step_q == POLY_LAST) begin
						state_q <= is_load_q ? S_DIV_WAIT : S_EMIT;
					end
				end
				S_DIV_WAIT: begin
					if (!div_busy) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					count_q <= widx_q + CW'(1);
					state_q <= S_IDLE;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("interval count above capacity");

	a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.emit |-> !(result_valid_q && result_stall))
		else $error("result overwritten while stalled");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (widx_q < MAX_CNT) && !div_busy)
		else $error("table write out of range or before slope is ready");

	a_write_grows: assert property (@(posedge clk) disable iff (!arst_n)
		we |=> count_q == $past(widx_q) + CW'(1))
		else $error("count not advanced after write");
`endif

endmodule

`default_nettype wire

// File: hdl/curvature_integrating_angle_lookup_unit.sv
// Load: the 63-step divider computes the slope; the previous-angle polynomial (7 steps)
//   runs beside it and is skipped for the first interval.
// Query: one table read per cycle until the interval that holds the position is found,
//   then 7 multiplier steps give the heading; a miss walks all N intervals.
// One word at a time; the next word is taken while a result waits in the output register.
// Reset clears the interval count and control state; the table RAM is not cleared.
`default_nettype none

module curvature_integrating_angle_lookup_unit
	import cial_pkg::*;
#(
	parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic               cmd,
	input  wire logic [5:0]         slot,
	input  wire logic signed [31:0] position,
	input  wire logic signed [31:0] end_position,
	input  wire logic signed [31:0] start_curvature,
	input  wire logic signed [31:0] end_curvature,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic signed [31:0]      heading,
	output logic                    found
);

	localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int EW = $bits(entry_t);

	dp_cmd_t            dp_cmd;
	logic               hit;
	logic               div_busy;
	logic               div_start;
	logic signed [32:0] div_dy;
	logic signed [32:0] div_dx;
	logic signed [63:0] div_quotient;
	logic [AW-1:0]      raddr;
	logic [AW-1:0]      waddr;
	logic               we;
	logic [EW-1:0]      ram_rdata;
	entry_t             rd_entry;
	entry_t             wr_entry;

	assign rd_entry = entry_t'(ram_rdata);

	cial_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_INTERVALS)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wr_entry),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	cial_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dy      (div_dy),
		.dx      (div_dx),
		.busy    (div_busy),
		.quotient(div_quotient)
	);

	cial_dp u_dp (
		.clk            (clk),
		.cmd_in         (dp_cmd),
		.position       (position),
		.end_position   (end_position),
		.start_curvature(start_curvature),
		.end_curvature  (end_curvature),
		.rd_entry       (rd_entry),
		.div_quotient   (div_quotient),
		.div_dy         (div_dy),
		.div_dx         (div_dx),
		.wr_entry       (wr_entry),
		.hit            (hit),
		.heading        (heading),
		.found          (found)
	);

	cial_ctrl #(
		.MAX_INTERVALS(MAX_INTERVALS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.cmd         (cmd),
		.slot        (slot),
		.hit         (hit),
		.div_busy    (div_busy),
		.div_start   (div_start),
		.raddr       (raddr),
		.we          (we),
		.waddr       (waddr),
		.dp_cmd      (dp_cmd),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

endmodule

`default_nettype wire
